/* rtl/jts_pkg.sv */
// Shared types, token codes and character constants for the JSON token scanner.
package jts_pkg;

    // Default width of the byte offset counters
    localparam int OFFSET_BITS_DEF = 32;

    // Number of result slots one item can fill
    localparam int MAX_TOKENS = 4;

    // Token kinds
    localparam logic [3:0] K_LBRACE = 4'd0;
    localparam logic [3:0] K_RBRACE = 4'd1;
    localparam logic [3:0] K_LBRACK = 4'd2;
    localparam logic [3:0] K_RBRACK = 4'd3;
    localparam logic [3:0] K_COLON  = 4'd4;
    localparam logic [3:0] K_COMMA  = 4'd5;
    localparam logic [3:0] K_TRUE   = 4'd6;
    localparam logic [3:0] K_FALSE  = 4'd7;
    localparam logic [3:0] K_NULL   = 4'd8;
    localparam logic [3:0] K_STRING = 4'd9;
    localparam logic [3:0] K_NUMBER = 4'd10;
    localparam logic [3:0] K_END    = 4'd11;
    localparam logic [3:0] K_ERROR  = 4'd12;

    // Error codes
    localparam logic [1:0] E_NONE    = 2'd0;
    localparam logic [1:0] E_LITERAL = 2'd1;
    localparam logic [1:0] E_UNTERM  = 2'd2;
    localparam logic [1:0] E_BYTE    = 2'd3;

    // Literal selectors
    localparam logic [1:0] L_TRUE  = 2'd0;
    localparam logic [1:0] L_FALSE = 2'd1;
    localparam logic [1:0] L_NULL  = 2'd2;

    // Source characters
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_U      = 8'h75;

    // One result item
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] start;
        logic [31:0] length;
        logic [1:0]  code;
        logic        last;
    } t_token;

    // Expected byte of a literal tail: "rue", "alse", "ull"
    function automatic logic [7:0] lit_char(input logic [1:0] which, input logic [1:0] pos);
        logic [7:0] ch;
        case ({which, pos})
            {L_TRUE,  2'd0}: ch = CH_R;
            {L_TRUE,  2'd1}: ch = CH_U;
            {L_TRUE,  2'd2}: ch = CH_E;
            {L_FALSE, 2'd0}: ch = CH_A;
            {L_FALSE, 2'd1}: ch = CH_L;
            {L_FALSE, 2'd2}: ch = CH_S;
            {L_FALSE, 2'd3}: ch = CH_E;
            {L_NULL,  2'd0}: ch = CH_U;
            {L_NULL,  2'd1}: ch = CH_L;
            {L_NULL,  2'd2}: ch = CH_L;
            default:         ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Length of a literal tail
    function automatic logic [2:0] lit_len(input logic [1:0] which);
        logic [2:0] n;
        case (which)
            L_TRUE:  n = 3'd3;
            L_FALSE: n = 3'd4;
            L_NULL:  n = 3'd3;
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    // Token kind of a finished literal
    function automatic logic [3:0] lit_kind(input logic [1:0] which);
        logic [3:0] k;
        case (which)
            L_TRUE:  k = K_TRUE;
            L_FALSE: k = K_FALSE;
            L_NULL:  k = K_NULL;
            default: k = K_ERROR;
        endcase
        return k;
    endfunction

endpackage

/* rtl/jts_if.sv */
// Valid/ready channels for source bytes and emitted tokens.
interface jts_in_if;
    logic       valid;
    logic       ready;
    logic       has_byte;
    logic [7:0] char_in;
    logic       is_last;

    modport source (output valid, has_byte, char_in, is_last, input ready);
    modport sink (input valid, has_byte, char_in, is_last, output ready);
endinterface

interface jts_tok_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic [1:0]  error_code;
    logic        run_last;

    modport source (output valid, token_kind, token_start, token_length, error_code,
                    run_last, input ready);
    modport sink (input valid, token_kind, token_start, token_length, error_code,
                  run_last, output ready);
endinterface

/* rtl/json_token_scanner_top.sv */
// Streaming JSON tokenizer: at most one source byte per item in, tokens out.
//
// Each accepted item is scanned in the cycle it is taken and its tokens (up to
// four) are loaded into a small output buffer; the first one is visible on
// o_tok the next cycle. The buffer drains one token per cycle while o_tok is
// ready, so an item yielding zero or one token keeps a rate of one item per
// cycle unless the output stalls; an item yielding more holds the input off
// until all of its tokens but the last have left. The input side is ready
// whenever the buffer is empty or its last token leaves in the same cycle.
// Strings carry no escapes and report their content extent; numbers are an
// optional minus and digits with an optional fraction. An item with is_last
// set closes any pending token, emits an end token and restarts offsets at
// zero. Offsets wrap at 2^OFFSET_BITS and are reported in their low 32 bits.
module json_token_scanner_top
    import jts_pkg::*;
#(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    jts_in_if.sink           i_src,
    jts_tok_if.source        o_tok
);

    typedef enum logic [2:0] {
        M_IDLE = 3'd0,
        M_LIT  = 3'd1,
        M_STR  = 3'd2,
        M_INT  = 3'd3,
        M_DOT  = 3'd4,
        M_FRAC = 3'd5
    } t_mode;

    typedef logic [OFFSET_BITS-1:0] t_off;

    localparam t_off ONE = OFFSET_BITS'(1);

    // Scanner state
    t_mode      r_mode,   n_mode;
    logic [1:0] r_lwhich, n_lwhich;
    logic [2:0] r_lpos,   n_lpos;
    t_off       r_off,    n_off;
    t_off       r_begin,  n_begin;

    // Output buffer
    t_token     r_tok [MAX_TOKENS];
    t_token     n_tok [MAX_TOKENS];
    logic [2:0] r_num;
    logic [2:0] cnt;

    logic       accept;
    logic       pop;

    // Build a token with offsets cut to 32 bits
    function automatic t_token make_tok(input logic [3:0] kind, input t_off s,
                                        input t_off l, input logic [1:0] code);
        t_token     t;
        logic [63:0] se;
        logic [63:0] le;
        se       = 64'(s);
        le       = 64'(l);
        t.kind   = kind;
        t.start  = se[31:0];
        t.length = le[31:0];
        t.code   = code;
        t.last   = 1'b0;
        return t;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    // Handshakes
    assign pop          = o_tok.valid && o_tok.ready;
    assign i_src.ready  = (r_num == 3'd0) || ((r_num == 3'd1) && o_tok.ready);
    assign accept       = i_src.valid && i_src.ready;

    // Scan one item: next state and the tokens it yields
    always_comb begin
        logic [7:0] c;
        logic       rescan;
        t_off       off;
        t_off       prev;
        t_off       fprev;
        logic [2:0] lp1;

        c        = i_src.char_in;
        rescan   = 1'b0;
        off      = r_off;
        prev     = r_off - ONE;
        fprev    = '0;
        lp1      = r_lpos + 3'd1;
        n_mode   = r_mode;
        n_lwhich = r_lwhich;
        n_lpos   = r_lpos;
        n_off    = r_off;
        n_begin  = r_begin;
        cnt      = 3'd0;
        for (int i = 0; i < MAX_TOKENS; i++) begin
            n_tok[i] = '0;
        end

        if (i_src.has_byte) begin
            // Continue the pending token
            case (r_mode)
                M_LIT: begin
                    if ((r_lpos < lit_len(r_lwhich)) && (c == lit_char(r_lwhich, r_lpos[1:0])))
                    begin
                        n_lpos = lp1;
                        if (lp1 >= lit_len(r_lwhich)) begin
                            if (cnt < 3'd4) begin
                                n_tok[cnt[1:0]] = make_tok(lit_kind(r_lwhich), r_begin,
                                                           off + ONE - r_begin, E_NONE);
                                cnt = cnt + 3'd1;
                            end
                            n_mode = M_IDLE;
                        end
                    end else begin
                        if (cnt < 3'd4) begin
                            n_tok[cnt[1:0]] = make_tok(K_ERROR, r_begin, off - r_begin,
                                                       E_LITERAL);
                            cnt = cnt + 3'd1;
                        end
                        n_mode = M_IDLE;
                        rescan = 1'b1;
                    end
                end
                M_STR: begin
                    if (c == CH_QUOTE) begin
                        if (cnt < 3'd4) begin
                            n_tok[cnt[1:0]] = make_tok(K_STRING, r_begin, off - r_begin,
                                                       E_NONE);
                            cnt = cnt + 3'd1;
                        end
                        n_mode = M_IDLE;
                    end
                end
                M_INT, M_FRAC: begin
                    if (is_digit(c)) begin
                        n_mode = r_mode;
                    end else if ((c == CH_DOT) && (r_mode == M_INT)) begin
                        n_mode = M_DOT;
                    end else begin
                        if (cnt < 3'd4) begin
                            n_tok[cnt[1:0]] = make_tok(K_NUMBER, r_begin, off - r_begin,
                                                       E_NONE);
                            cnt = cnt + 3'd1;
                        end
                        n_mode = M_IDLE;
                        rescan = 1'b1;
                    end
                end
                M_DOT: begin
                    if (is_digit(c)) begin
                        n_mode = M_FRAC;
                    end else begin
                        // Number stops before the dot, the dot itself is an error
                        if (cnt < 3'd4) begin
                            n_tok[cnt[1:0]] = make_tok(K_NUMBER, r_begin, prev - r_begin,
                                                       E_NONE);
                            cnt = cnt + 3'd1;
                        end
                        if (cnt < 3'd4) begin
                            n_tok[cnt[1:0]] = make_tok(K_ERROR, prev, ONE, E_BYTE);
                            cnt = cnt + 3'd1;
                        end
                        n_mode = M_IDLE;
                        rescan = 1'b1;
                    end
                end
                default: begin
                    n_mode = M_IDLE;
                    rescan = 1'b1;
                end
            endcase

            // Scan the byte from idle
            if (rescan) begin
                case (c)
                    CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COLON, CH_COMMA: begin
                        if (cnt < 3'd4) begin
                            n_tok[cnt[1:0]] = make_tok(
                                (c == CH_LBRACE) ? K_LBRACE :
                                (c == CH_RBRACE) ? K_RBRACE :
                                (c == CH_LBRACK) ? K_LBRACK :
                                (c == CH_RBRACK) ? K_RBRACK :
                                (c == CH_COLON)  ? K_COLON  : K_COMMA,
                                off, ONE, E_NONE);
                            cnt = cnt + 3'd1;
                        end
                    end
                    CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
                        n_mode = M_IDLE;
                    end
                    CH_T, CH_F, CH_N: begin
                        n_mode   = M_LIT;
                        n_lwhich = (c == CH_T) ? L_TRUE : (c == CH_F) ? L_FALSE : L_NULL;
                        n_lpos   = 3'd0;
                        n_begin  = off;
                    end
                    CH_QUOTE: begin
                        n_mode  = M_STR;
                        n_begin = off + ONE;
                    end
                    default: begin
                        if ((c == CH_MINUS) || is_digit(c)) begin
                            n_mode  = M_INT;
                            n_begin = off;
                        end else if (cnt < 3'd4) begin
                            n_tok[cnt[1:0]] = make_tok(K_ERROR, off, ONE, E_BYTE);
                            cnt = cnt + 3'd1;
                        end
                    end
                endcase
            end

            n_off = off + ONE;
        end

        // Close the source: flush the pending token, then the end token
        if (i_src.is_last) begin
            fprev = n_off - ONE;
            case (n_mode)
                M_LIT: begin
                    if (cnt < 3'd4) begin
                        n_tok[cnt[1:0]] = make_tok(K_ERROR, n_begin, n_off - n_begin, E_LITERAL);
                        cnt = cnt + 3'd1;
                    end
                end
                M_STR: begin
                    if (cnt < 3'd4) begin
                        n_tok[cnt[1:0]] = make_tok(K_ERROR, n_begin, n_off - n_begin, E_UNTERM);
                        cnt = cnt + 3'd1;
                    end
                end
                M_INT, M_FRAC: begin
                    if (cnt < 3'd4) begin
                        n_tok[cnt[1:0]] = make_tok(K_NUMBER, n_begin, n_off - n_begin, E_NONE);
                        cnt = cnt + 3'd1;
                    end
                end
                M_DOT: begin
                    if (cnt < 3'd4) begin
                        n_tok[cnt[1:0]] = make_tok(K_NUMBER, n_begin, fprev - n_begin, E_NONE);
                        cnt = cnt + 3'd1;
                    end
                    if (cnt < 3'd4) begin
                        n_tok[cnt[1:0]] = make_tok(K_ERROR, fprev, ONE, E_BYTE);
                        cnt = cnt + 3'd1;
                    end
                end
                default: begin
                    n_lpos = n_lpos;
                end
            endcase
            if (cnt < 3'd4) begin
                n_tok[cnt[1:0]] = make_tok(K_END, n_off, '0, E_NONE);
                cnt = cnt + 3'd1;
            end
            n_mode   = M_IDLE;
            n_lwhich = 2'd0;
            n_lpos   = 3'd0;
            n_off    = '0;
            n_begin  = '0;
        end

        // Mark the last token of this item
        if (cnt != 3'd0) begin
            n_tok[cnt[1:0] - 2'd1].last = 1'b1;
        end
    end

    // Hold state; load the buffer on accept, else advance it on pop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_lwhich <= 2'd0;
            r_lpos   <= 3'd0;
            r_off    <= '0;
            r_begin  <= '0;
            r_num    <= 3'd0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_lwhich <= n_lwhich;
            r_lpos   <= n_lpos;
            r_off    <= n_off;
            r_begin  <= n_begin;
            r_num    <= cnt;
            r_tok    <= n_tok;
        end else if (pop) begin
            r_num <= r_num - 3'd1;
            for (int i = 0; i < MAX_TOKENS - 1; i++) begin
                r_tok[i] <= r_tok[i+1];
            end
        end
    end

    // Drive the token channel from the head of the buffer
    assign o_tok.valid        = (r_num != 3'd0);
    assign o_tok.token_kind   = r_tok[0].kind;
    assign o_tok.token_start  = r_tok[0].start;
    assign o_tok.token_length = r_tok[0].length;
    assign o_tok.error_code   = r_tok[0].code;
    assign o_tok.run_last     = r_tok[0].last;

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the JSON token scanner: directed and random sources.
`timescale 1ns / 100ps

module tb_top;
    import jts_pkg::*;

    localparam int ITEM_TARGET = 360;
    localparam int STALL_LIMIT = 1000;
    localparam int END_SETTLE  = 16;

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_LIT, SCAN_STR, SCAN_INT, SCAN_DOT, SCAN_FRAC
    } t_scan_mode;

    logic i_clk;
    logic i_rst_n;

    jts_in_if  src_if();
    jts_tok_if tok_if();

    json_token_scanner_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_if),
        .o_tok   (tok_if)
    );

    // Literal tails after the first byte, indexed by literal selector
    string lit_tails [3] = '{"rue", "alse", "ull"};
    logic [7:0] punct_set [6] = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COLON, CH_COMMA};
    logic [7:0] space_set [4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};

    // Scanner state mirror
    t_scan_mode  sc_mode;
    logic [1:0]  sc_lit;
    logic [2:0]  sc_pos;
    logic [31:0] sc_off;
    logic [31:0] sc_begin;

    t_token item_toks [$];
    t_token tokens_due [$];

    int  mismatches = 0;
    int  items_sent = 0;
    bit  steady = 1'b0;
    int  out_stall = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Token prediction
    // ------------------------------------------------------------------
    function automatic void push_token(logic [3:0] k, logic [31:0] s, logic [31:0] n,
                                       logic [1:0] c);
        if (item_toks.size() < MAX_TOKENS)
            item_toks.push_back('{kind: k, start: s, length: n, code: c, last: 1'b0});
    endfunction

    function automatic bit digit_byte(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic [3:0] literal_token(logic [1:0] w);
        case (w)
            L_TRUE:  return K_TRUE;
            L_FALSE: return K_FALSE;
            L_NULL:  return K_NULL;
            default: return K_ERROR;
        endcase
    endfunction

    // Scan one byte from the idle mode
    function automatic void scan_from_idle(logic [7:0] c, logic [31:0] off);
        case (c)
            CH_LBRACE: push_token(K_LBRACE, off, 1, E_NONE);
            CH_RBRACE: push_token(K_RBRACE, off, 1, E_NONE);
            CH_LBRACK: push_token(K_LBRACK, off, 1, E_NONE);
            CH_RBRACK: push_token(K_RBRACK, off, 1, E_NONE);
            CH_COLON:  push_token(K_COLON, off, 1, E_NONE);
            CH_COMMA:  push_token(K_COMMA, off, 1, E_NONE);
            CH_SPACE, CH_TAB, CH_LF, CH_CR: begin
            end
            CH_T, CH_F, CH_N: begin
                sc_mode  = SCAN_LIT;
                sc_lit   = (c == CH_T) ? L_TRUE : (c == CH_F) ? L_FALSE : L_NULL;
                sc_pos   = 3'd0;
                sc_begin = off;
            end
            CH_QUOTE: begin
                sc_mode  = SCAN_STR;
                sc_begin = off + 32'd1;
            end
            default: begin
                if (c == CH_MINUS || digit_byte(c)) begin
                    sc_mode  = SCAN_INT;
                    sc_begin = off;
                end else begin
                    push_token(K_ERROR, off, 1, E_BYTE);
                end
            end
        endcase
    endfunction

    // Advance the scanner by one source byte
    function automatic void scan_byte(logic [7:0] c);
        logic [31:0] off;
        logic [31:0] prev;
        off  = sc_off;
        prev = off - 32'd1;
        case (sc_mode)
            SCAN_LIT: begin
                if (sc_pos < lit_tails[sc_lit].len() && c == lit_tails[sc_lit][sc_pos]) begin
                    sc_pos = sc_pos + 3'd1;
                    if (sc_pos >= lit_tails[sc_lit].len()) begin
                        push_token(literal_token(sc_lit), sc_begin, off + 32'd1 - sc_begin,
                                   E_NONE);
                        sc_mode = SCAN_IDLE;
                    end
                end else begin
                    push_token(K_ERROR, sc_begin, off - sc_begin, E_LITERAL);
                    sc_mode = SCAN_IDLE;
                    scan_from_idle(c, off);
                end
            end
            SCAN_STR: begin
                if (c == CH_QUOTE) begin
                    push_token(K_STRING, sc_begin, off - sc_begin, E_NONE);
                    sc_mode = SCAN_IDLE;
                end
            end
            SCAN_INT, SCAN_FRAC: begin
                if (digit_byte(c)) begin
                end else if (c == CH_DOT && sc_mode == SCAN_INT) begin
                    sc_mode = SCAN_DOT;
                end else begin
                    push_token(K_NUMBER, sc_begin, off - sc_begin, E_NONE);
                    sc_mode = SCAN_IDLE;
                    scan_from_idle(c, off);
                end
            end
            SCAN_DOT: begin
                if (digit_byte(c)) begin
                    sc_mode = SCAN_FRAC;
                end else begin
                    // drop the dot from the number and flag it on its own
                    push_token(K_NUMBER, sc_begin, prev - sc_begin, E_NONE);
                    push_token(K_ERROR, prev, 1, E_BYTE);
                    sc_mode = SCAN_IDLE;
                    scan_from_idle(c, off);
                end
            end
            default: begin
                sc_mode = SCAN_IDLE;
                scan_from_idle(c, off);
            end
        endcase
        sc_off = off + 32'd1;
    endfunction

    // Close the source: flush pending token, emit end, restart offsets
    function automatic void scan_end();
        logic [31:0] prev;
        prev = sc_off - 32'd1;
        case (sc_mode)
            SCAN_LIT:  push_token(K_ERROR, sc_begin, sc_off - sc_begin, E_LITERAL);
            SCAN_STR:  push_token(K_ERROR, sc_begin, sc_off - sc_begin, E_UNTERM);
            SCAN_INT, SCAN_FRAC: push_token(K_NUMBER, sc_begin, sc_off - sc_begin, E_NONE);
            SCAN_DOT: begin
                push_token(K_NUMBER, sc_begin, prev - sc_begin, E_NONE);
                push_token(K_ERROR, prev, 1, E_BYTE);
            end
            default: begin
            end
        endcase
        push_token(K_END, sc_off, 0, E_NONE);
        sc_mode  = SCAN_IDLE;
        sc_lit   = 2'd0;
        sc_pos   = 3'd0;
        sc_off   = 32'd0;
        sc_begin = 32'd0;
    endfunction

    // Work out the tokens of one accepted item and queue them
    function automatic void scan_item(bit hb, logic [7:0] c, bit last);
        item_toks.delete();
        if (hb)
            scan_byte(c);
        if (last)
            scan_end();
        if (item_toks.size() > 0)
            item_toks[item_toks.size() - 1].last = 1'b1;
        foreach (item_toks[i])
            tokens_due.push_back(item_toks[i]);
    endfunction

    // ------------------------------------------------------------------
    // Source side
    // ------------------------------------------------------------------
    function automatic int draw_gap();
        return steady ? 0 : $urandom_range(0, 4);
    endfunction

    // Send one item and hold until it is taken
    task automatic send_item(bit hb, logic [7:0] c, bit last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            src_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        src_if.valid    <= 1'b1;
        src_if.has_byte <= hb;
        src_if.char_in  <= c;
        src_if.is_last  <= last;
        do @(posedge i_clk); while (!src_if.ready);
        scan_item(hb, c, last);
        if (hb || last)
            items_sent++;
    endtask

    task automatic send_text(string s, bit end_it);
        for (int i = 0; i < s.len(); i++)
            send_item(1'b1, s[i], end_it && i == s.len() - 1);
    endtask

    // Hold the source off until every queued token has come out
    task automatic wait_drained();
        src_if.valid <= 1'b0;
        do @(posedge i_clk); while (tokens_due.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Token side: random stalls and checking
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_token got;
        t_token want;
        if (!i_rst_n) begin
            tok_if.ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (tok_if.valid && tok_if.ready) begin
                got = '{kind: tok_if.token_kind, start: tok_if.token_start,
                        length: tok_if.token_length, code: tok_if.error_code,
                        last: tok_if.run_last};
                if (tokens_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"[%0t] unexpected token kind %0d start %0d len %0d ",
                                  "code %0d last %0d"},
                                 $realtime, got.kind, got.start, got.length, got.code, got.last);
                end else begin
                    want = tokens_due.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"[%0t] token mismatch: expected kind %0d start %0d len %0d ",
                                      "code %0d last %0d, got kind %0d start %0d len %0d ",
                                      "code %0d last %0d"},
                                     $realtime, want.kind, want.start, want.length, want.code,
                                     want.last, got.kind, got.start, got.length, got.code,
                                     got.last);
                    end
                end
                out_stall = draw_gap();
            end
            if (out_stall > 0) begin
                tok_if.ready <= 1'b0;
                out_stall--;
            end else begin
                tok_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((src_if.valid && src_if.ready) || (tok_if.valid && tok_if.ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("json_token_scanner_top verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Punctuation, empty string and a signed fraction closed by a brace
    task automatic test_object_with_fraction();
        send_text("{\"\":-.5}", 1'b1);
    endtask

    // Number followed by a dot with no digit, then a bracket
    task automatic test_dot_without_digit();
        send_text("1.]", 1'b0);
    endtask

    // Minus with no digits still makes a number
    task automatic test_lone_minus();
        send_text("-,", 1'b0);
    endtask

    // Literal broken by a byte that is then rescanned as unsupported
    task automatic test_bad_literal();
        send_text("nulx", 1'b0);
    endtask

    // Unsupported bytes at both ends of the byte range
    task automatic test_unsupported_bytes();
        send_item(1'b1, 8'h00, 1'b0);
        send_item(1'b1, 8'hFF, 1'b0);
    endtask

    // End of source with a string, a literal and a dangling dot pending
    task automatic test_end_of_source();
        send_text("\"\t", 1'b0);
        send_item(1'b0, 8'hFF, 1'b1);
        send_item(1'b0, 8'h00, 1'b0);
        send_text("f", 1'b1);
        send_text("9.", 1'b1);
    endtask

    // Mostly well-formed token streams with random content and some noise
    task automatic test_random_documents();
        logic [7:0] text [$];
        logic [7:0] b;
        int ntok;
        int pick;
        int n;
        int ending;
        int srcs;
        srcs = 0;
        while (items_sent < ITEM_TARGET) begin
            text.delete();
            steady = ($urandom_range(0, 3) == 0);
            ntok = $urandom_range(1, 10);
            repeat (ntok) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    text.push_back(punct_set[$urandom_range(0, 5)]);
                end else if (pick < 45) begin
                    // literal, sometimes cut short or corrupted
                    n = $urandom_range(0, 2);
                    text.push_back(n == 0 ? CH_T : n == 1 ? CH_F : CH_N);
                    for (int i = 0; i < lit_tails[n].len(); i++)
                        text.push_back(lit_tails[n][i]);
                    case ($urandom_range(0, 7))
                        0: void'(text.pop_back());
                        1: text[text.size() - 1 - $urandom_range(0, 2)] =
                               8'($urandom_range(0, 255));
                        default: begin
                        end
                    endcase
                end else if (pick < 65) begin
                    text.push_back(CH_QUOTE);
                    repeat ($urandom_range(0, 5)) begin
                        b = 8'($urandom_range(0, 255));
                        text.push_back(b == CH_QUOTE ? CH_A : b);
                    end
                    if ($urandom_range(0, 9) != 0)
                        text.push_back(CH_QUOTE);
                end else if (pick < 88) begin
                    if ($urandom_range(0, 2) == 0)
                        text.push_back(CH_MINUS);
                    repeat ($urandom_range(0, 3)) begin
                        b = CH_0 + 8'($urandom_range(0, 9));
                        text.push_back(b);
                    end
                    n = $urandom_range(0, 9);
                    if (n <= 4)
                        text.push_back(CH_DOT);
                    if (n < 4) begin
                        repeat ($urandom_range(1, 2)) begin
                            b = CH_0 + 8'($urandom_range(0, 9));
                            text.push_back(b);
                        end
                    end
                end else if (pick < 95) begin
                    repeat ($urandom_range(1, 2))
                        text.push_back(space_set[$urandom_range(0, 3)]);
                end else begin
                    b = 8'($urandom_range(0, 255));
                    text.push_back(b);
                end
            end
            // end on the last byte, by a bare end item, or run on into the next source
            ending = $urandom_range(0, 9);
            foreach (text[i]) begin
                if ($urandom_range(0, 31) == 0)
                    send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
                send_item(1'b1, text[i], ending < 6 && i == text.size() - 1);
            end
            if (ending >= 6 && ending < 9)
                send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
            srcs++;
            if (srcs == 20)
                wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        src_if.valid    <= 1'b0;
        src_if.has_byte <= 1'b0;
        src_if.char_in  <= 8'h00;
        src_if.is_last  <= 1'b0;
        i_rst_n         <= 1'b0;
        sc_mode  = SCAN_IDLE;
        sc_lit   = 2'd0;
        sc_pos   = 3'd0;
        sc_off   = 32'd0;
        sc_begin = 32'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_object_with_fraction();
        test_dot_without_digit();
        test_lone_minus();
        test_bad_literal();
        test_unsupported_bytes();
        test_end_of_source();
        wait_drained();
        test_random_documents();

        // Drain and let the pipeline settle
        wait_drained();
        repeat (END_SETTLE) @(posedge i_clk);
        if (mismatches == 0 && tokens_due.size() == 0)
            $display("json_token_scanner_top verification clean");
        else
            $display("json_token_scanner_top verification failed");
        $finish;
    end

endmodule
